// ===== rtl/core/lfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpd_pkg: shared constants for the line-follow PD stepper drive
// Field widths, fixed-point formats and divider sizing used by the
// channel interfaces and the drive core.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  // Timer clock in hertz; periods are expressed in ticks of this clock.
  localparam int unsigned CLOCK_HZ = 2000000;

  // Payload and register widths.
  localparam int SAMPLE_W = 12;
  localparam int FREQ_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int PER_W    = 16;
  localparam int CMP_W    = PER_W - 1;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_MID_TARGET  = 3'd0,
    REG_LEFT_THR    = 3'd1,
    REG_RIGHT_THR   = 3'd2,
    REG_PROP_GAIN   = 3'd3,
    REG_DERIV_GAIN  = 3'd4,
    REG_BASE_FREQ   = 3'd5,
    REG_FREQ_FLOOR  = 3'd6,
    REG_FREQ_CEIL   = 3'd7
  } reg_idx_t;

  // Fixed-point formats. Frequencies are scaled by 2^FRAC_W.
  localparam int FRAC_W   = 28;
  localparam int ERR_W    = SAMPLE_W + 1;
  localparam int FSUM_W   = 32;
  // The filtered error settles within +/-2^20 (units of 1/256 count).
  localparam int FILT_W   = FSUM_W - 8;

  // Filter coefficients: old weight 179/256, new weight 77/256.
  localparam int ALPHA_OLD   = 179;
  localparam int ALPHA_NEW_S = 77 * 256;
  localparam int FILT_ROUND  = 128;

  // Shared multiplier: signed MA_W by unsigned GAIN_W.
  localparam int MA_W = 25;
  localparam int MP_W = MA_W + GAIN_W + 1;

  // PD term and the (1 +/- u) factor, split in two halves for the multiplier.
  localparam int U_W  = MP_W;
  localparam int W_LO = 21;
  localparam int FQ_W = 59;
  localparam logic [U_W-1:0] Q_ONE = {{(U_W - FRAC_W - 1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

  // Restoring divider sizing.
  localparam int CLK_W = $clog2(CLOCK_HZ + 1);
  localparam int DVD_W = CLK_W + FRAC_W;
  localparam int DSR_W = FREQ_W + FRAC_W + PER_W;
  localparam int CNT_W = $clog2(PER_W + 1);
  localparam logic [DVD_W-1:0] CLK_DVD = DVD_W'(CLOCK_HZ);
  localparam logic [DVD_W-1:0] CLK_N   = DVD_W'(CLOCK_HZ) << FRAC_W;

endpackage

// ===== rtl/core/lfpd_if.sv =====
// ----------------------------------------------------------------------------
// lfpd_if: sample and drive channels
// Valid/ready channels carrying one sample triple in and one motor drive
// result out.
// ----------------------------------------------------------------------------
interface lfpd_in_if;
  import lfpd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] left_sample;
  logic [SAMPLE_W-1:0] mid_sample;
  logic [SAMPLE_W-1:0] right_sample;

  modport source (output valid, output left_sample, output mid_sample,
                  output right_sample, input ready);
  modport sink   (input valid, input left_sample, input mid_sample,
                  input right_sample, output ready);
endinterface

interface lfpd_out_if;
  import lfpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [PER_W-1:0] left_period;
  logic [PER_W-1:0] right_period;
  logic [CMP_W-1:0] left_compare;
  logic [CMP_W-1:0] right_compare;
  logic             limit_flag;

  modport source (output valid, output left_period, output right_period,
                  output left_compare, output right_compare,
                  output limit_flag, input ready);
  modport sink   (input valid, input left_period, input right_period,
                  input left_compare, input right_compare,
                  input limit_flag, output ready);
endinterface

// ===== rtl/core/line_follow_pd_stepper_drive.sv =====
// ----------------------------------------------------------------------------
// line_follow_pd_stepper_drive: PD steering for a two-stepper line follower
// Filters the middle sensor error, forms a PD term, and turns the left and
// right step frequencies into timer periods with one shared multiplier and
// one shared restoring divider.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------
//  in_ch    | in  | valid / ready    | left_sample, mid_sample, right_sample
//  out_ch   | out | valid / ready    | left/right_period, left/right_compare, limit_flag
//  config   | in  | wr_en            | wr_index, wr_data
//
// After its transfer, each item runs through a filter state (S_FILT), S_MULP and S_MULD
// for the PD term, then per motor S_MULLO, S_MULHI, a select state (S_SEL) and 17 divider
// steps in S_DIV, then an output state (S_OUT); an override skips the multiplier states.
// in_ch.ready is high only while idle. A stalled out_ch holds the core only when
// the next result is ready before the last one drains.
// Synchronous reset restores the register defaults and a zero filter.
// ----------------------------------------------------------------------------
module line_follow_pd_stepper_drive (
  input  logic                        clk,
  input  logic                        rst,
  lfpd_in_if.sink                     in_ch,
  lfpd_out_if.source                  out_ch,
  input  logic                        wr_en,
  input  logic [lfpd_pkg::IDX_W-1:0]  wr_index,
  input  logic [lfpd_pkg::CFG_W-1:0]  wr_data
);
  import lfpd_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FILT  = 9'b000000010,
    S_MULP  = 9'b000000100,
    S_MULD  = 9'b000001000,
    S_MULLO = 9'b000010000,
    S_MULHI = 9'b000100000,
    S_SEL   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [SAMPLE_W-1:0] mid_target;
  logic [SAMPLE_W-1:0] left_threshold;
  logic [SAMPLE_W-1:0] right_threshold;
  logic [GAIN_W-1:0]   prop_gain;
  logic [GAIN_W-1:0]   deriv_gain;
  logic [FREQ_W-1:0]   base_freq;
  logic [FREQ_W-1:0]   freq_floor;
  logic [FREQ_W-1:0]   freq_ceil;

  // Filter state and per-item working registers.
  logic signed [FILT_W-1:0] filt;
  logic signed [FILT_W-1:0] f_prev;
  logic [SAMPLE_W-1:0]      mid_s;
  logic                     ovr_l;
  logic                     ovr_r;
  logic signed [U_W-1:0]    u_acc;
  logic signed [FQ_W-1:0]   fq;
  logic                     side;
  logic                     flag;
  logic [DVD_W-1:0]         rem;
  logic [DSR_W-1:0]         dsr;
  logic [PER_W:0]           quo;
  logic [CNT_W-1:0]         cnt;
  logic [PER_W-1:0]         lp;
  logic [PER_W-1:0]         rp;
  logic                     lstop;
  logic                     rstop;

  // Filter update.
  logic signed [ERR_W-1:0]  err;
  logic signed [FSUM_W-1:0] fsum;
  logic signed [FILT_W-1:0] fn_calc;

  always_comb begin
    err     = $signed({1'b0, mid_s}) - $signed({1'b0, mid_target});
    fsum    = FSUM_W'(filt) * FSUM_W'(ALPHA_OLD) + FSUM_W'(err) * FSUM_W'(ALPHA_NEW_S)
              + FSUM_W'(FILT_ROUND);
    // Taking the upper bits of a two's complement sum is a floor divide by 256.
    fn_calc = fsum[FSUM_W-1:8];
  end

  // Shared multiplier and the (1 +/- u) factor of the current motor.
  logic signed [U_W-1:0]  w;
  logic signed [MA_W-1:0] mul_a;
  logic [GAIN_W-1:0]      mul_b;
  logic signed [MP_W-1:0] prod;

  always_comb begin
    w = side ? $signed(Q_ONE) + u_acc : $signed(Q_ONE) - u_acc;
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MULP: begin
        mul_a = MA_W'(filt);
        mul_b = prop_gain;
      end
      S_MULD: begin
        mul_a = MA_W'(filt) - MA_W'(f_prev);
        mul_b = deriv_gain;
      end
      S_MULLO: begin
        mul_a = $signed({{(MA_W - W_LO){1'b0}}, w[W_LO-1:0]});
        mul_b = base_freq;
      end
      S_MULHI: begin
        mul_a = MA_W'($signed(w[U_W-1:W_LO]));
        mul_b = base_freq;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = MP_W'(mul_a) * MP_W'($signed({1'b0, mul_b}));
  end

  // Limit selection for the current motor.
  logic signed [FQ_W-1:0] min_q;
  logic signed [FQ_W-1:0] max_q;
  logic                   use_lim;
  logic                   clamp;
  logic                   stop;
  logic [FREQ_W-1:0]      lim_f;

  always_comb begin
    min_q   = $signed(FQ_W'({freq_floor, {FRAC_W{1'b0}}}));
    max_q   = $signed(FQ_W'({freq_ceil, {FRAC_W{1'b0}}}));
    use_lim = 1'b1;
    clamp   = 1'b0;
    stop    = 1'b0;
    lim_f   = freq_floor;
    // The right override takes precedence over the left one.
    if (ovr_r) begin
      lim_f = side ? freq_floor : freq_ceil;
      stop  = side;
    end else if (ovr_l) begin
      lim_f = side ? freq_ceil : freq_floor;
      stop  = !side;
    end else if (fq <= min_q) begin
      clamp = 1'b1;
    end else if (fq >= max_q) begin
      clamp = 1'b1;
      lim_f = freq_ceil;
    end else begin
      use_lim = 1'b0;
    end
  end

  // Restoring divider step. A set top quotient bit means the period overflows.
  logic             ge;
  logic [PER_W:0]   q_step;
  logic [PER_W-1:0] per;

  always_comb begin
    ge     = {{(DSR_W - DVD_W){1'b0}}, rem} >= dsr;
    q_step = {quo[PER_W-1:0], ge};
    per    = q_step[PER_W] ? {PER_W{1'b1}} : q_step[PER_W-1:0];
  end

  assign in_ch.ready = (state == S_IDLE);

  // Control, configuration and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_ch.valid    <= 1'b0;
      filt            <= '0;
      mid_target      <= SAMPLE_W'(2854);
      left_threshold  <= SAMPLE_W'(3288);
      right_threshold <= SAMPLE_W'(2234);
      prop_gain       <= GAIN_W'(1268);
      deriv_gain      <= GAIN_W'(169);
      base_freq       <= FREQ_W'(327);
      freq_floor      <= FREQ_W'(60);
      freq_ceil       <= FREQ_W'(600);
    end else begin
      if (wr_en) begin
        unique case (reg_idx_t'(wr_index))
          REG_MID_TARGET: mid_target      <= wr_data[SAMPLE_W-1:0];
          REG_LEFT_THR:   left_threshold  <= wr_data[SAMPLE_W-1:0];
          REG_RIGHT_THR:  right_threshold <= wr_data[SAMPLE_W-1:0];
          REG_PROP_GAIN:  prop_gain       <= wr_data[GAIN_W-1:0];
          REG_DERIV_GAIN: deriv_gain      <= wr_data[GAIN_W-1:0];
          REG_BASE_FREQ:  base_freq       <= wr_data[FREQ_W-1:0];
          REG_FREQ_FLOOR: freq_floor      <= wr_data[FREQ_W-1:0];
          REG_FREQ_CEIL:  freq_ceil       <= wr_data[FREQ_W-1:0];
        endcase
      end

      // In S_OUT the output state below decides the valid bit on its own.
      if (out_ch.valid && out_ch.ready && state != S_OUT) begin
        out_ch.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            state <= S_FILT;
          end
        end
        S_FILT: begin
          filt  <= fn_calc;
          state <= (ovr_l || ovr_r) ? S_SEL : S_MULP;
        end
        S_MULP:  state <= S_MULD;
        S_MULD:  state <= S_MULLO;
        S_MULLO: state <= S_MULHI;
        S_MULHI: state <= S_SEL;
        S_SEL:   state <= S_DIV;
        S_DIV: begin
          if (cnt == CNT_W'(PER_W)) begin
            if (!side) begin
              state <= (ovr_l || ovr_r) ? S_SEL : S_MULLO;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          mid_s <= in_ch.mid_sample;
          ovr_l <= in_ch.left_sample < left_threshold;
          ovr_r <= in_ch.right_sample < right_threshold;
        end
      end
      S_FILT: begin
        f_prev <= filt;
        flag   <= ovr_l || ovr_r;
        side   <= 1'b0;
      end
      S_MULP: u_acc <= U_W'(prod);
      S_MULD: u_acc <= u_acc - U_W'(prod);
      S_MULLO: fq <= FQ_W'(prod);
      S_MULHI: fq <= fq + (FQ_W'(prod) <<< W_LO);
      S_SEL: begin
        flag <= flag || clamp;
        if (!side) begin
          lstop <= stop;
        end else begin
          rstop <= stop;
        end
        if (use_lim) begin
          rem <= CLK_DVD;
          dsr <= DSR_W'({lim_f, {PER_W{1'b0}}});
        end else begin
          // Here the scaled frequency lies strictly between the limits.
          rem <= CLK_N;
          dsr <= {fq[DSR_W-PER_W-1:0], {PER_W{1'b0}}};
        end
        quo <= '0;
        cnt <= '0;
      end
      S_DIV: begin
        if (ge) begin
          rem <= rem - dsr[DVD_W-1:0];
        end
        dsr <= dsr >> 1;
        quo <= q_step;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(PER_W)) begin
          if (!side) begin
            lp   <= per;
            side <= 1'b1;
          end else begin
            rp <= per;
          end
        end
      end
      S_OUT: begin
        if (!out_ch.valid || out_ch.ready) begin
          out_ch.left_period   <= lp;
          out_ch.right_period  <= rp;
          out_ch.left_compare  <= lstop ? '0 : lp[PER_W-1:1];
          out_ch.right_compare <= rstop ? '0 : rp[PER_W-1:1];
          out_ch.limit_flag    <= flag;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/lfpd_checker.sv =====
// ----------------------------------------------------------------------------
// lfpd_checker: port-level checks for the line-follow PD stepper drive
// Watches the sample and drive channels of the top level over time.
// ----------------------------------------------------------------------------
module lfpd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lfpd_pkg::PER_W-1:0]   left_period,
  input logic [lfpd_pkg::PER_W-1:0]   right_period,
  input logic [lfpd_pkg::CMP_W-1:0]   left_compare,
  input logic [lfpd_pkg::CMP_W-1:0]   right_compare,
  input logic                         limit_flag
);
  import lfpd_pkg::*;

  // The core works on one item at a time.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample transfer accepted while an item is in progress");

  // Without clamp or override each compare is half its period.
  a_compare_half: assert property (@(posedge clk) disable iff (rst)
    out_valid && !limit_flag |->
      left_compare == left_period[PER_W-1:1] && right_compare == right_period[PER_W-1:1])
    else $error("compare differs from half period with no limit");

  // A stopped motor only comes from an override, which raises the flag.
  a_stop_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((left_compare == '0 && left_period[PER_W-1:1] != '0) ||
                  (right_compare == '0 && right_period[PER_W-1:1] != '0)) |-> limit_flag)
    else $error("motor stopped without limit flag");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(left_period) && $stable(right_period))
    else $error("stalled result changed");

endmodule

bind line_follow_pd_stepper_drive lfpd_checker u_lfpd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .left_period   (out_ch.left_period),
  .right_period  (out_ch.right_period),
  .left_compare  (out_ch.left_compare),
  .right_compare (out_ch.right_compare),
  .limit_flag    (out_ch.limit_flag)
);
